// ===== design/evpip_pkg.sv =====
package evpip_pkg;

  // Store and coordinate sizing
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 24;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int ENTRY_BITS   = 2 * COORD_BITS + 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  // Opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // One queued command word
  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] a;
    logic signed [COORD_BITS-1:0] b;
    logic                         np;
  } cmd_t;

endpackage

// ===== design/even_odd_point_in_polygon_core.sv =====
// Even-odd point-in-polygon tester over a stored union of polygons.
// Input channel (in_valid/in_ready) carries one word: opcode, coord_a, coord_b,
// new_polygon. Opcode clear empties the vertex store, append adds one vertex if
// the store has room (new_polygon marks the start of a polygon), test checks the
// point against all stored polygons. Opcode three is taken and dropped.
// Output channel (out_valid/out_ready) carries one word per test: outside is 1
// when the point lies in no polygon, 0 when it lies in at least one.
// Words pass through a two-entry queue; clear and append are each done in the
// back end as they are popped. A test reads one stored vertex per cycle from
// the store and holds the back end until its result is on the output.
// Reset empties the store and the queue and drops any pending result.
// When the receiver stalls, the result is held on the output; the front keeps
// taking words while the queue has room, and clears and appends keep running.
// A further test walks the store and then waits for the output to free up.
module even_odd_point_in_polygon_core
  import evpip_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] coord_a,
  input  logic signed [COORD_BITS-1:0] coord_b,
  input  logic                         new_polygon,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         outside
);

  logic q_full;
  logic push;
  cmd_t push_word;
  logic q_pop;
  logic q_valid;
  cmd_t q_word;

  evpip_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .coord_a     (coord_a),
    .coord_b     (coord_b),
    .new_polygon (new_polygon),
    .q_full      (q_full),
    .push        (push),
    .push_word   (push_word)
  );

  evpip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_word  (q_word)
  );

  evpip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .outside   (outside)
  );

endmodule

// ===== design/evpip_ram.sv =====
module evpip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/evpip_front.sv =====
module evpip_front
  import evpip_pkg::*;
(
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] coord_a,
  input  logic signed [COORD_BITS-1:0] coord_b,
  input  logic                         new_polygon,
  input  logic                         q_full,
  output logic                         push,
  output cmd_t                         push_word
);

  // Take a word whenever the queue has room
  assign in_ready = !q_full;

  // Drop words with no meaning; queue the rest for the back end
  assign push = in_valid && !q_full && (opcode != OP_NONE);

  always_comb begin
    push_word.op = opcode;
    push_word.a  = coord_a;
    push_word.b  = coord_b;
    push_word.np = new_polygon;
  end

endmodule

// ===== design/evpip_queue.sv =====
module evpip_queue
  import evpip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_word,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_word
);

  cmd_t                      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill;

  assign full      = (fill == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_word  = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !(pop && pop_valid)) begin
        fill <= fill + 1'b1;
      end else if (!push && pop && pop_valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/evpip_back.sv =====
module evpip_back
  import evpip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_word,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic outside
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } back_state_t;

  back_state_t state;

  // Vertex store access
  logic [COUNT_BITS-1:0]        vcount;
  logic [ADDR_BITS-1:0]         walk_idx;
  logic                         wr_en;
  logic [ENTRY_BITS-1:0]        wr_data;
  logic                         rd_en;
  logic [ENTRY_BITS-1:0]        rd_data;
  logic                         last_issue;

  // Test point
  logic signed [COORD_BITS-1:0] pa;
  logic signed [COORD_BITS-1:0] pb;

  // Read return and edge assembly
  logic                         rd_valid;
  logic                         rd_last;
  logic                         rd_start;
  logic signed [COORD_BITS-1:0] rd_a;
  logic signed [COORD_BITS-1:0] rd_b;
  logic                         have_poly;
  logic                         pend_close;
  logic signed [COORD_BITS-1:0] first_a;
  logic signed [COORD_BITS-1:0] first_b;
  logic signed [COORD_BITS-1:0] prev_a;
  logic signed [COORD_BITS-1:0] prev_b;

  logic                         e_valid;
  logic                         e_last;
  logic signed [COORD_BITS-1:0] e_ai;
  logic signed [COORD_BITS-1:0] e_bi;
  logic signed [COORD_BITS-1:0] e_aj;
  logic signed [COORD_BITS-1:0] e_bj;

  logic                         d_valid;
  logic                         d_last;
  logic                         d_straddle;
  logic signed [DIFF_BITS-1:0]  d_d;
  logic signed [DIFF_BITS-1:0]  d_x1;
  logic signed [DIFF_BITS-1:0]  d_x2;
  logic signed [DIFF_BITS-1:0]  d_x3;

  logic                         m_valid;
  logic                         m_last;
  logic                         m_straddle;
  logic                         m_dpos;
  logic signed [PROD_BITS-1:0]  m_pl;
  logic signed [PROD_BITS-1:0]  m_pr;

  logic                         flip;
  logic                         parity;
  logic                         hit;
  logic                         done;

  evpip_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (vcount[ADDR_BITS-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (walk_idx),
    .rd_data (rd_data)
  );

  // Decode command word and store access
  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign wr_en      = q_pop && (q_word.op == OP_APPEND) &&
                      (vcount < COUNT_BITS'(MAX_VERTICES));
  assign wr_data    = {q_word.np || (vcount == '0), q_word.a, q_word.b};
  assign rd_en      = (state == ST_WALK);
  assign last_issue = (COUNT_BITS'(walk_idx) + COUNT_BITS'(1)) == vcount;

  assign rd_start = rd_data[ENTRY_BITS-1];
  assign rd_a     = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_b     = rd_data[COORD_BITS-1:0];

  // Crossing decision on registered products
  assign flip = m_straddle && (m_dpos ? (m_pl < m_pr) : (m_pr < m_pl));

  // Finish once every stage has drained and the output slot is free
  assign done = (state == ST_FLUSH) && !rd_valid && !pend_close && !e_valid &&
                !d_valid && !m_valid && (!out_valid || out_ready);

  // Sequencer and vertex count
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      vcount <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_word.op)
              OP_CLEAR: begin
                vcount <= '0;
              end
              OP_APPEND: begin
                if (wr_en) begin
                  vcount <= vcount + 1'b1;
                end
              end
              OP_TEST: begin
                state <= (vcount == '0) ? ST_FLUSH : ST_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          if (last_issue) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold test point and walk address
  always_ff @(posedge clk) begin
    if (q_pop && (q_word.op == OP_TEST)) begin
      pa       <= q_word.a;
      pb       <= q_word.b;
      walk_idx <= '0;
    end else if (rd_en) begin
      walk_idx <= walk_idx + 1'b1;
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_last    <= 1'b0;
      pend_close <= 1'b0;
      e_valid    <= 1'b0;
      d_valid    <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      rd_valid   <= rd_en;
      rd_last    <= rd_en && last_issue;
      pend_close <= rd_valid && rd_last;
      e_valid    <= rd_valid ? (!rd_start || have_poly) : pend_close;
      d_valid    <= e_valid;
      m_valid    <= d_valid;
    end
  end

  // Assemble edges: one per vertex, the closing edge when a polygon ends
  always_ff @(posedge clk) begin
    if (q_pop && (q_word.op == OP_TEST)) begin
      have_poly <= 1'b0;
    end else if (rd_valid) begin
      if (rd_start) begin
        e_ai      <= first_a;
        e_bi      <= first_b;
        e_aj      <= prev_a;
        e_bj      <= prev_b;
        e_last    <= 1'b1;
        first_a   <= rd_a;
        first_b   <= rd_b;
        have_poly <= 1'b1;
      end else begin
        e_ai   <= rd_a;
        e_bi   <= rd_b;
        e_aj   <= prev_a;
        e_bj   <= prev_b;
        e_last <= 1'b0;
      end
      prev_a <= rd_a;
      prev_b <= rd_b;
    end else if (pend_close) begin
      e_ai   <= first_a;
      e_bi   <= first_b;
      e_aj   <= prev_a;
      e_bj   <= prev_b;
      e_last <= 1'b1;
    end
  end

  // Straddle test and differences
  always_ff @(posedge clk) begin
    d_last     <= e_last;
    d_straddle <= (pa < e_ai) != (pa < e_aj);
    d_d        <= DIFF_BITS'(e_aj) - DIFF_BITS'(e_ai);
    d_x1       <= DIFF_BITS'(pb) - DIFF_BITS'(e_bi);
    d_x2       <= DIFF_BITS'(e_bj) - DIFF_BITS'(e_bi);
    d_x3       <= DIFF_BITS'(pa) - DIFF_BITS'(e_ai);
  end

  // Cross products
  always_ff @(posedge clk) begin
    m_last     <= d_last;
    m_straddle <= d_straddle;
    m_dpos     <= !d_d[DIFF_BITS-1] && (d_d != '0);
    m_pl       <= d_x1 * d_d;
    m_pr       <= d_x2 * d_x3;
  end

  // Fold crossings into polygon parity and the union flag
  always_ff @(posedge clk) begin
    if (q_pop && (q_word.op == OP_TEST)) begin
      parity <= 1'b0;
      hit    <= 1'b0;
    end else if (m_valid) begin
      if (m_last) begin
        hit    <= hit || (parity ^ flip);
        parity <= 1'b0;
      end else begin
        parity <= parity ^ flip;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      outside <= !hit;
    end
  end

endmodule

// ===== design/evpip_checker.sv =====
module evpip_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic outside
);

  // Reset drops any pending result
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word visible after reset");

  // Reset leaves the queue empty, so the input side is ready
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // A stalled result stays and keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outside))
    else $error("stalled result word changed or dropped");

endmodule

bind even_odd_point_in_polygon_core evpip_checker u_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import evpip_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_WORDS = 1400;
  localparam int IDLE_PERCENT = 28;
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 900;
  localparam int DRAIN_CYCLES = MAX_VERTICES + 40;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int COORD_MAX    = 8388607;
  localparam int COORD_MIN    = -8388608;

  typedef struct {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] a;
    logic signed [COORD_BITS-1:0] b;
    logic                         np;
    bit                           hold;
  } word_t;

  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic [1:0]                   opcode      = OP_NONE;
  logic signed [COORD_BITS-1:0] coord_a     = '0;
  logic signed [COORD_BITS-1:0] coord_b     = '0;
  logic                         new_polygon = 1'b0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic                         outside;

  even_odd_point_in_polygon_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .coord_a     (coord_a),
    .coord_b     (coord_b),
    .new_polygon (new_polygon),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .outside     (outside)
  );

  // Pending words, expected verdicts and run counters
  word_t pending_words[$];
  bit    expected_outside[$];
  bit    hold_next;
  bit    drained = 1'b1;
  int    words_queued;
  int    words_loaded;
  int    words_taken;
  int    results_seen;
  int    tests_predicted;
  int    inside_verdicts;
  int    appends_dropped;
  int    store_fills;
  int    mismatches;
  int    cycle_count;

  // Shadow copy of the vertex store
  logic signed [COORD_BITS-1:0] shadow_a[MAX_VERTICES];
  logic signed [COORD_BITS-1:0] shadow_b[MAX_VERTICES];
  bit                           shadow_start[MAX_VERTICES];
  int                           shadow_count;

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(string what, bit got, bit want);
    $display("MISMATCH at %0t: %s (outside got %0b, want %0b)", $time, what, got, want);
    mismatches++;
  endtask

  // Does edge (i, j) cross the ray from the point toward larger second coordinate?
  function automatic bit edge_crosses(int i, int j, longint pa, longint pb);
    longint ai, aj, bi, bj, d, lhs, rhs;
    ai = shadow_a[i];
    aj = shadow_a[j];
    bi = shadow_b[i];
    bj = shadow_b[j];
    if ((pa < ai) == (pa < aj)) return 1'b0;
    d   = aj - ai;
    lhs = (pb - bi) * d;
    rhs = (bj - bi) * (pa - ai);
    return (d > 0) ? (lhs < rhs) : (rhs < lhs);
  endfunction

  // Walk every polygon; the point is inside the union when any parity is odd
  function automatic bit point_outside(longint pa, longint pb);
    int s, e, i, j;
    bit odd;
    s = 0;
    while (s < shadow_count) begin
      e = s + 1;
      while (e < shadow_count && !shadow_start[e]) e++;
      odd = 1'b0;
      for (i = s; i < e; i++) begin
        j = (i == s) ? e - 1 : i - 1;
        if (edge_crosses(i, j, pa, pb)) odd = ~odd;
      end
      if (odd) return 1'b0;
      s = e;
    end
    return 1'b1;
  endfunction

  // Update the shadow store for one accepted word and queue any verdict
  task automatic absorb_word(logic [1:0] op, logic signed [COORD_BITS-1:0] a,
                             logic signed [COORD_BITS-1:0] b, logic np);
    bit verdict;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_APPEND: begin
        if (shadow_count < MAX_VERTICES) begin
          shadow_a[shadow_count]     = a;
          shadow_b[shadow_count]     = b;
          shadow_start[shadow_count] = np || (shadow_count == 0);
          shadow_count++;
        end else begin
          appends_dropped++;
        end
      end
      OP_TEST: begin
        verdict = point_outside(a, b);
        expected_outside.insert(expected_outside.size(), verdict);
        tests_predicted++;
        if (!verdict) inside_verdicts++;
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(logic [1:0] op, int a, int b, int np);
    word_t w;
    w.op   = op;
    w.a    = a[COORD_BITS-1:0];
    w.b    = b[COORD_BITS-1:0];
    w.np   = np[0];
    w.hold = hold_next;
    hold_next = 1'b0;
    pending_words.insert(pending_words.size(), w);
    if (op != OP_NONE) words_queued++;
  endtask

  function automatic int pick_centre(int span);
    int lim;
    if (span == 0) return 0;
    lim = COORD_MAX - span;
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Span zero means the whole field, with the extremes drawn often
  function automatic logic signed [COORD_BITS-1:0] pick_coord(int span, int centre);
    if (span == 0) begin
      case ($urandom_range(0, 19))
        0:       return COORD_BITS'(COORD_MIN);
        1:       return COORD_BITS'(COORD_MAX);
        default: return COORD_BITS'($urandom());
      endcase
    end
    return COORD_BITS'(centre + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly a clear first, a few polygons with random content, then points in the same box
  task automatic queue_polygon_set();
    int span, ca, cb, polys, verts, tests, p, v, t, k;
    logic signed [COORD_BITS-1:0] va[$];
    logic signed [COORD_BITS-1:0] vb[$];
    logic signed [COORD_BITS-1:0] pa, pb;
    case ($urandom_range(0, 2))
      0:       span = 24;
      1:       span = 3000;
      default: span = 0;
    endcase
    ca = pick_centre(span);
    cb = pick_centre(span);
    if ($urandom_range(0, 9) < 8) queue_word(OP_CLEAR, $urandom(), $urandom(), $urandom());
    polys = $urandom_range(1, 4);
    for (p = 0; p < polys; p++) begin
      verts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      for (v = 0; v < verts; v++) begin
        pa = pick_coord(span, ca);
        pb = pick_coord(span, cb);
        va.insert(va.size(), pa);
        vb.insert(vb.size(), pb);
        if (v == 0) queue_word(OP_APPEND, pa, pb, $urandom_range(0, 9) != 0);
        else        queue_word(OP_APPEND, pa, pb, $urandom_range(0, 19) == 0);
      end
    end
    tests = $urandom_range(2, 8);
    for (t = 0; t < tests; t++) begin
      pa = pick_coord(span, ca);
      pb = pick_coord(span, cb);
      if ($urandom_range(0, 3) == 0) begin
        k  = $urandom_range(0, va.size() - 1);
        pa = va[k];
        if ($urandom_range(0, 1) == 0) pb = vb[k];
      end
      queue_word(OP_TEST, pa, pb, $urandom());
    end
  endtask

  // Overfill the store so the last appends are dropped, then test
  task automatic queue_store_fill();
    int ca, cb, k, extra;
    ca    = pick_centre(3000);
    cb    = pick_centre(3000);
    extra = $urandom_range(1, 5);
    queue_word(OP_CLEAR, $urandom(), $urandom(), $urandom());
    for (k = 0; k < MAX_VERTICES + extra; k++) begin
      queue_word(OP_APPEND, pick_coord(3000, ca), pick_coord(3000, cb),
                 $urandom_range(0, 15) == 0);
    end
    for (k = 0; k < 4; k++) begin
      queue_word(OP_TEST, pick_coord(3000, ca), pick_coord(3000, cb), $urandom());
    end
    store_fills++;
  endtask

  // Present pending words; idle only between words, hold where asked
  always @(posedge clk) begin
    word_t w;
    bit    next_valid;
    bit    idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid && !in_ready;
      if (!next_valid && pending_words.size() > 0) begin
        idle = !(words_loaded >= CALM_FIRST && words_loaded < CALM_LAST) &&
               ($urandom_range(0, 99) < IDLE_PERCENT);
        if (!idle && (!pending_words[0].hold || (drained && !in_valid))) begin
          w = pending_words.pop_front();
          opcode      <= w.op;
          coord_a     <= w.a;
          coord_b     <= w.b;
          new_polygon <= w.np;
          next_valid  = 1'b1;
          words_loaded++;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Snapshot between edges whether every verdict has arrived
  always @(negedge clk) drained <= (expected_outside.size() == 0);

  // Check results, predict accepted words, and stall the output at random
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_outside.size() == 0) begin
          report_mismatch("result with no test pending", outside, 1'b0);
        end else begin
          want = expected_outside.pop_front();
          if (outside !== want) report_mismatch("wrong verdict", outside, want);
        end
      end
      if (in_valid && in_ready) begin
        absorb_word(opcode, coord_a, coord_b, new_polygon);
        words_taken++;
      end
      out_ready <= (words_taken >= CALM_FIRST && words_taken < CALM_LAST) ||
                   ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, expected_outside.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int seq, directed;
    shadow_count = 0;

    // Directed: empty store, ignored opcode, square, degenerate and extreme polygons
    queue_word(OP_TEST, COORD_MIN, COORD_MAX, 1'b0);
    queue_word(OP_NONE, 24'h5A5A5A, -1, 1'b1);
    queue_word(OP_APPEND, -256, -256, 1'b0);
    queue_word(OP_APPEND, 256, -256, 1'b0);
    queue_word(OP_APPEND, 256, 256, 1'b0);
    queue_word(OP_APPEND, -256, 256, 1'b0);
    queue_word(OP_TEST, 0, 0, 1'b0);
    queue_word(OP_TEST, 512, 0, 1'b1);
    queue_word(OP_TEST, 256, 0, 1'b0);
    queue_word(OP_TEST, -256, -256, 1'b0);
    queue_word(OP_TEST, 0, -256, 1'b0);
    queue_word(OP_APPEND, 1000, 1000, 1'b1);
    queue_word(OP_TEST, 1000, 1000, 1'b0);
    queue_word(OP_APPEND, 2000, 0, 1'b1);
    queue_word(OP_APPEND, 3000, 100, 1'b0);
    queue_word(OP_TEST, 2500, 0, 1'b0);
    queue_word(OP_APPEND, COORD_MIN, COORD_MIN, 1'b1);
    queue_word(OP_APPEND, COORD_MAX, COORD_MIN, 1'b0);
    queue_word(OP_APPEND, 0, COORD_MAX, 1'b0);
    queue_word(OP_TEST, 0, 1000000, 1'b0);
    queue_word(OP_TEST, COORD_MAX, COORD_MAX, 1'b1);
    hold_next = 1'b1;
    queue_word(OP_CLEAR, -1, -1, 1'b1);
    queue_word(OP_TEST, 0, 0, 1'b0);
    queue_word(OP_NONE, 0, 0, 1'b0);
    directed = words_queued;

    // Random: mostly well-formed polygon sets, some noise, two store fills
    seq = 0;
    while (words_queued < directed + RANDOM_WORDS) begin
      seq++;
      if (seq % 7 == 0) hold_next = 1'b1;
      if (seq == 3 || seq == 30) begin
        queue_store_fill();
      end else if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 4))
          queue_word(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
      end else begin
        queue_polygon_set();
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Drain: all words taken, all verdicts back, then a quiet spell
    while (pending_words.size() > 0 || in_valid || expected_outside.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d words: %0d point tests (%0d inside), %0d results checked",
             words_taken, tests_predicted, inside_verdicts, results_seen);
    $display("Filled the store %0d times, %0d appends dropped, %0d mismatches",
             store_fills, appends_dropped, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
